// ----- sv/bdrq_pkg.sv -----
`timescale 1ns / 1ps
package bdrq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int NUM_BUTTONS_DEF = 9;

	localparam int TIME_W     = 48;
	localparam int BTN_W      = 4;
	localparam int CNT_W      = 8;
	localparam int TOTAL_W    = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int POLL_W     = 20;
	localparam int DELAY_W    = 24;
	localparam int SW_W       = 4;
	localparam int OUT_DATA_W = 128;

	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	localparam logic [CFG_IDX_W-1:0] CFG_POLL_PERIOD   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PERIOD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STABLE        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DIR_MASK      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SWITCH        = 3'd5;

	localparam logic [POLL_W-1:0]  RST_POLL_PERIOD   = 20'd10000;
	localparam logic [DELAY_W-1:0] RST_REPEAT_DELAY  = 24'd400000;
	localparam logic [DELAY_W-1:0] RST_REPEAT_PERIOD = 24'd100000;
	localparam logic [CNT_W-1:0]   RST_STABLE        = 8'd3;
	localparam logic [15:0]        RST_DIR_MASK      = 16'd15;
	localparam logic [SW_W-1:0]    RST_SWITCH        = 4'd7;
	localparam logic [CNT_W-1:0]   MIN_STABLE        = 8'd2;

	typedef enum logic [1:0] {
		KIND_PRESS   = 2'd0,
		KIND_RELEASE = 2'd1,
		KIND_REPEAT  = 2'd2
	} kind_t;

	typedef struct packed {
		logic [TIME_W-1:0] tstamp;
		logic [BTN_W-1:0]  button;
		kind_t             kind;
	} entry_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_START,
		OP_BTN,
		OP_SCAN_OWN,
		OP_REAL_FULL,
		OP_EVICT,
		OP_SCAN_RPT,
		OP_FIN
	} dp_op_t;

	typedef enum logic [1:0] {
		ACT_NEXT,
		ACT_REAL,
		ACT_RPT
	} act_t;

	typedef struct packed {
		logic done_early;
		act_t act;
		logic at_end;
		logic hit;
		logic full;
		logic last;
		logic out_free;
	} dp_status_t;

	typedef struct packed {
		logic               poll_status;
		logic               pop_valid;
		entry_t             ent;
		logic               sw_latched;
		logic               sw_level;
		logic               switch_changed;
		logic [TOTAL_W-1:0] drops;
		logic [TOTAL_W-1:0] overflows;
	} result_t;

	function automatic logic [TIME_W-1:0] sat_add48(input logic [TIME_W-1:0] a,
		input logic [DELAY_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {{(TIME_W + 1 - DELAY_W){1'b0}}, b};
		return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
	endfunction

endpackage

// ----- sv/bdrq_ctrl.sv -----
`timescale 1ns / 1ps
module bdrq_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  bdrq_pkg::dp_status_t   st,
	output bdrq_pkg::dp_op_t       op
);
	import bdrq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_BTN,
		S_OWN,
		S_FULL,
		S_EVICT,
		S_RPT,
		S_FIN
	} state_t;

	state_t state_q;
	state_t state_nx;
	state_t after_btn;

	assign in_ready  = (state_q == S_IDLE);
	assign after_btn = st.last ? S_FIN : S_BTN;

	always_comb begin
		op       = OP_NONE;
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op       = OP_LOAD;
					state_nx = S_START;
				end
			end
			S_START: begin
				op       = OP_START;
				state_nx = st.done_early ? S_FIN : S_BTN;
			end
			S_BTN: begin
				op = OP_BTN;
				unique case (st.act)
					ACT_REAL: state_nx = S_OWN;
					ACT_RPT:  state_nx = S_RPT;
					default:  state_nx = after_btn;
				endcase
			end
			S_OWN: begin
				op = OP_SCAN_OWN;
				if (st.at_end) state_nx = S_FULL;
			end
			S_FULL: begin
				op       = OP_REAL_FULL;
				state_nx = st.full ? S_EVICT : after_btn;
			end
			S_EVICT: begin
				op = OP_EVICT;
				priority if (st.at_end) state_nx = after_btn;
				else if (st.hit) state_nx = S_FULL;
				else state_nx = S_EVICT;
			end
			S_RPT: begin
				op = OP_SCAN_RPT;
				if (st.at_end || st.hit) state_nx = after_btn;
			end
			S_FIN: begin
				op = OP_FIN;
				if (st.out_free) state_nx = S_IDLE;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

// ----- sv/bdrq_dp.sv -----
`timescale 1ns / 1ps
module bdrq_dp #(
	parameter int QUEUE_DEPTH = bdrq_pkg::QUEUE_DEPTH_DEF,
	parameter int NUM_BUTTONS = bdrq_pkg::NUM_BUTTONS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bdrq_pkg::dp_op_t                    op,
	output bdrq_pkg::dp_status_t                st,
	input  logic                                in_pop,
	input  logic [bdrq_pkg::TIME_W-1:0]         in_time,
	input  logic [NUM_BUTTONS-1:0]              in_levels,
	input  logic                                cfg_we,
	input  logic [bdrq_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [bdrq_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output logic                                out_valid,
	input  logic                                out_ready,
	output bdrq_pkg::result_t                   out_res
);
	import bdrq_pkg::*;

	localparam int PW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FW  = $clog2(QUEUE_DEPTH + 1);
	localparam int BIW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
	localparam logic [FW-1:0]  FILL_MAX = FW'(QUEUE_DEPTH);
	localparam logic [BIW-1:0] BTN_LAST = BIW'(NUM_BUTTONS - 1);

	// Configuration.
	logic [POLL_W-1:0]      period_q;
	logic [DELAY_W-1:0]     delay_q;
	logic [DELAY_W-1:0]     rperiod_q;
	logic [CNT_W-1:0]       samples_q;
	logic [NUM_BUTTONS-1:0] mask_q;
	logic [SW_W-1:0]        sw_q;

	// Current request.
	logic                   pop_q;
	logic [TIME_W-1:0]      now_q;
	logic [NUM_BUTTONS-1:0] raw_q;
	logic                   status_q;
	logic                   pv_q;
	entry_t                 pe_q;

	// Per-button state.
	logic [NUM_BUTTONS-1:0] cand_q;
	logic [NUM_BUTTONS-1:0] stable_q;
	logic [CNT_W-1:0]       cnt_q    [NUM_BUTTONS];
	logic [TIME_W-1:0]      settle_q [NUM_BUTTONS];
	logic [TIME_W-1:0]      due_q    [NUM_BUTTONS];

	logic [TIME_W-1:0]  next_q;
	logic               polled_q;
	logic [FW-1:0]      fill_q;
	logic [FW-1:0]      ptr_q;
	logic [BIW-1:0]     bidx_q;
	logic [TOTAL_W-1:0] drops_q;
	logic [TOTAL_W-1:0] overs_q;
	logic               sw_latched_q;
	logic               sw_level_q;
	logic               sw_moved_q;
	logic               out_valid_q;
	result_t            out_q;

	entry_t queue_q [QUEUE_DEPTH];

	logic              raw_b;
	logic [CNT_W-1:0]  cnt_b;
	logic [CNT_W-1:0]  thr;
	logic [CNT_W-1:0]  ncnt;
	logic              settle_wr;
	logic              qualified;
	logic              is_sw;
	logic              early;
	logic              continuous;
	logic [TIME_W:0]   gap_limit;
	act_t              act;
	entry_t            ent;
	logic              own_hit;
	logic              any_hit;
	logic              at_end;
	logic              full;
	logic              out_free;
	logic [BTN_W-1:0]  btn_num;
	logic              remove;
	logic [PW-1:0]     rm_pos;
	logic              append;
	entry_t            app_ent;

	always_comb begin
		raw_b     = raw_q[bidx_q];
		cnt_b     = cnt_q[bidx_q];
		thr       = (samples_q < MIN_STABLE) ? MIN_STABLE : samples_q;
		settle_wr = 1'b0;
		if (raw_b != cand_q[bidx_q] || cnt_b == '0) begin
			ncnt = 8'd1;
		end else if (cnt_b < thr) begin
			ncnt      = cnt_b + 8'd1;
			settle_wr = (ncnt == thr);
		end else begin
			ncnt = cnt_b;
		end
		qualified = (ncnt >= thr);
		btn_num   = BTN_W'(bidx_q);
		is_sw     = (btn_num == sw_q);
		if (!qualified || is_sw) begin
			act = ACT_NEXT;
		end else if (raw_b != stable_q[bidx_q]) begin
			act = ACT_REAL;
		end else if (raw_b && mask_q[bidx_q] && now_q >= due_q[bidx_q]) begin
			act = ACT_RPT;
		end else begin
			act = ACT_NEXT;
		end
	end

	assign early      = polled_q && (now_q < next_q);
	assign gap_limit  = {1'b0, next_q} + {{(TIME_W + 1 - POLL_W){1'b0}}, period_q};
	assign continuous = !polled_q || ({1'b0, now_q} < gap_limit);
	assign ent        = queue_q[ptr_q[PW-1:0]];
	assign any_hit    = (ent.kind == KIND_REPEAT);
	assign own_hit    = any_hit && (ent.button == btn_num);
	assign at_end     = (ptr_q >= fill_q);
	assign full       = (fill_q == FILL_MAX);
	assign out_free   = !out_valid_q || out_ready;

	always_comb begin
		st.done_early = pop_q || early;
		st.act        = act;
		st.at_end     = at_end;
		st.hit        = (op == OP_EVICT) ? any_hit : own_hit;
		st.full       = full;
		st.last       = (bidx_q == BTN_LAST);
		st.out_free   = out_free;
	end

	// Queue edits: one removal with shift, or one append, per cycle.
	always_comb begin
		remove  = 1'b0;
		rm_pos  = ptr_q[PW-1:0];
		append  = 1'b0;
		app_ent = '{tstamp: now_q, button: btn_num, kind: KIND_REPEAT};
		unique case (op)
			OP_START: begin
				remove = pop_q && (fill_q != '0);
				rm_pos = '0;
			end
			OP_SCAN_OWN:  remove = !at_end && own_hit;
			OP_EVICT:     remove = !at_end && any_hit;
			OP_REAL_FULL: begin
				append  = !full;
				app_ent = '{tstamp: settle_q[bidx_q], button: btn_num,
					kind: (raw_b ? KIND_PRESS : KIND_RELEASE)};
			end
			OP_SCAN_RPT:  append = at_end && !full;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (remove) begin
			for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
				if (PW'(j) >= rm_pos) queue_q[j] <= queue_q[j + 1];
			end
		end else if (append) begin
			queue_q[fill_q[PW-1:0]] <= app_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q     <= RST_POLL_PERIOD;
			delay_q      <= RST_REPEAT_DELAY;
			rperiod_q    <= RST_REPEAT_PERIOD;
			samples_q    <= RST_STABLE;
			mask_q       <= RST_DIR_MASK[NUM_BUTTONS-1:0];
			sw_q         <= RST_SWITCH;
			pop_q        <= 1'b0;
			now_q        <= '0;
			raw_q        <= '0;
			status_q     <= 1'b0;
			pv_q         <= 1'b0;
			pe_q         <= '0;
			cand_q       <= '0;
			stable_q     <= '0;
			for (int b = 0; b < NUM_BUTTONS; b++) begin
				cnt_q[b]    <= '0;
				settle_q[b] <= '0;
				due_q[b]    <= '0;
			end
			next_q       <= '0;
			polled_q     <= 1'b0;
			fill_q       <= '0;
			ptr_q        <= '0;
			bidx_q       <= '0;
			drops_q      <= '0;
			overs_q      <= '0;
			sw_latched_q <= 1'b0;
			sw_level_q   <= 1'b0;
			sw_moved_q   <= 1'b0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_POLL_PERIOD:   period_q  <= cfg_wdata[POLL_W-1:0];
					CFG_REPEAT_DELAY:  delay_q   <= cfg_wdata[DELAY_W-1:0];
					CFG_REPEAT_PERIOD: rperiod_q <= cfg_wdata[DELAY_W-1:0];
					CFG_STABLE:        samples_q <= cfg_wdata[CNT_W-1:0];
					CFG_DIR_MASK:      mask_q    <= cfg_wdata[NUM_BUTTONS-1:0];
					CFG_SWITCH:        sw_q      <= cfg_wdata[SW_W-1:0];
					default: ;
				endcase
			end

			if (op == OP_FIN && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;

			unique case (op)
				OP_LOAD: begin
					pop_q    <= in_pop;
					now_q    <= in_time;
					raw_q    <= in_levels;
					status_q <= 1'b0;
					pv_q     <= 1'b0;
					pe_q     <= '0;
				end
				OP_START: begin
					bidx_q <= '0;
					if (pop_q) begin
						if (fill_q != '0) begin
							pv_q   <= 1'b1;
							pe_q   <= queue_q[0];
							fill_q <= fill_q - 1'b1;
						end
					end else if (!early) begin
						polled_q <= 1'b1;
						next_q   <= sat_add48(now_q, DELAY_W'(period_q));
						// A long gap between polls restarts every debounce count.
						if (!continuous) begin
							for (int b = 0; b < NUM_BUTTONS; b++) cnt_q[b] <= '0;
						end
					end
				end
				OP_BTN: begin
					cand_q[bidx_q] <= raw_b;
					cnt_q[bidx_q]  <= ncnt;
					if (settle_wr) settle_q[bidx_q] <= now_q;
					ptr_q <= '0;
					if (qualified && is_sw) begin
						if (!sw_latched_q) begin
							sw_latched_q <= 1'b1;
							sw_level_q   <= raw_b;
						end else if (raw_b != sw_level_q) begin
							sw_moved_q <= 1'b1;
						end
					end
					if (act == ACT_NEXT) bidx_q <= bidx_q + 1'b1;
				end
				OP_SCAN_OWN: begin
					if (!at_end) begin
						if (own_hit) fill_q <= fill_q - 1'b1;
						else ptr_q <= ptr_q + 1'b1;
					end
				end
				OP_REAL_FULL: begin
					if (!full) begin
						fill_q           <= fill_q + 1'b1;
						stable_q[bidx_q] <= raw_b;
						due_q[bidx_q]    <= sat_add48(now_q, delay_q);
						bidx_q           <= bidx_q + 1'b1;
					end else begin
						ptr_q <= '0;
					end
				end
				OP_EVICT: begin
					priority if (at_end) begin
						// No repeat to evict: the edge stays pending.
						overs_q  <= overs_q + 1'b1;
						status_q <= 1'b1;
						bidx_q   <= bidx_q + 1'b1;
					end else if (any_hit) begin
						fill_q  <= fill_q - 1'b1;
						drops_q <= drops_q + 1'b1;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				OP_SCAN_RPT: begin
					priority if (at_end || own_hit) begin
						if (own_hit && !at_end) drops_q <= drops_q + 1'b1;
						else if (full) drops_q <= drops_q + 1'b1;
						else fill_q <= fill_q + 1'b1;
						due_q[bidx_q] <= sat_add48(now_q, rperiod_q);
						bidx_q        <= bidx_q + 1'b1;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				OP_FIN: begin
					if (out_free) begin
						out_q.poll_status    <= status_q;
						out_q.pop_valid      <= pv_q;
						out_q.ent            <= pe_q;
						out_q.sw_latched     <= sw_latched_q;
						out_q.sw_level       <= sw_level_q;
						out_q.switch_changed <= sw_moved_q;
						out_q.drops          <= drops_q;
						out_q.overflows      <= overs_q;
					end
				end
				default: ;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

endmodule

// ----- sv/button_debounce_repeat_queue.sv -----
`timescale 1ns / 1ps
// Sequence: a pop or an early poll goes from the start state straight to the finish state,
// where its result is registered; an accepted poll also steps through each button in turn,
// plus for each queued edge a scan of the queue, one entry per cycle.
// Throughput: one request at a time; the next is taken in the cycle after the result is
// registered, which waits while an earlier result is still held back by m_tready.
// Reset: arst_n clears all debounce state, the queue fill, the totals and the registers
// to their defaults at once; queue contents are not cleared and are never read unwritten.
module button_debounce_repeat_queue #(
	parameter int QUEUE_DEPTH = bdrq_pkg::QUEUE_DEPTH_DEF,
	parameter int NUM_BUTTONS = bdrq_pkg::NUM_BUTTONS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// now_time[47:0], raw_levels[47+NUM_BUTTONS:48], zero fill
	input  logic [((bdrq_pkg::TIME_W + NUM_BUTTONS + 7) / 8) * 8 - 1:0] s_tdata,
	// opcode
	input  logic                                  s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// poll_status[0], edge_time[48:1], edge_button[52:49], edge_kind[54:53],
	// latched flag[55], latched level[56], switch_changed[57],
	// repeat_drop_count[89:58], overflow_count[121:90], zero fill
	output logic [bdrq_pkg::OUT_DATA_W-1:0]       m_tdata,
	// pop_valid
	output logic                                  m_tuser,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [bdrq_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [bdrq_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import bdrq_pkg::*;

	localparam int RES_W = $bits(result_t) - 1;

	dp_op_t     op;
	dp_status_t st;
	result_t    res;

	assign cfg_ready = 1'b1;

	bdrq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.op       (op)
	);

	bdrq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.NUM_BUTTONS (NUM_BUTTONS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.st        (st),
		.in_pop    (s_tuser),
		.in_time   (s_tdata[TIME_W-1:0]),
		.in_levels (s_tdata[TIME_W +: NUM_BUTTONS]),
		.cfg_we    (cfg_valid),
		.cfg_idx   (cfg_index),
		.cfg_wdata (cfg_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tuser = res.pop_valid;
	assign m_tdata = {{(OUT_DATA_W - RES_W){1'b0}},
		res.overflows, res.drops, res.switch_changed, res.sw_level, res.sw_latched,
		res.ent.kind, res.ent.button, res.ent.tstamp, res.poll_status};

endmodule

// ----- sv/bdrq_chk.sv -----
`timescale 1ns / 1ps
module bdrq_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [127:0] m_tdata,
	input logic         m_tuser
);

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_pop_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> !m_tdata[0] && (m_tdata[54:53] != 2'd3))
		else $error("popped edge with poll status or bad kind");

	a_no_edge: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[54:1] == 54'd0)
		else $error("edge fields set without a popped edge");

	a_switch: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[57] || m_tdata[56]) |-> m_tdata[55])
		else $error("switch state reported before it was latched");

endmodule

bind button_debounce_repeat_queue bdrq_chk u_bdrq_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ----- bench/button_debounce_repeat_queue_test.sv -----
`timescale 1ns / 1ps
module button_debounce_repeat_queue_test;
	import bdrq_pkg::*;

	localparam int NB = 9;
	localparam int QD = 16;
	localparam int CYCLE_LIMIT = 4000000;
	localparam int HOLD_CYCLES = 3000;
	localparam logic CMD_POLL = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	typedef struct {
		logic        op;
		logic [47:0] now;
		logic [8:0]  raw;
	} request_t;

	typedef struct packed {
		logic        status;
		logic        valid;
		logic [47:0] etime;
		logic [3:0]  btn;
		logic [1:0]  kind;
		logic        sw_ready;
		logic        sw_level;
		logic        sw_changed;
		logic [31:0] drops;
		logic [31:0] ovf;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic        m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	button_debounce_repeat_queue uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// Shadow of the debouncer state.
	logic [19:0] c_poll = RST_POLL_PERIOD;
	logic [23:0] c_delay = RST_REPEAT_DELAY;
	logic [23:0] c_period = RST_REPEAT_PERIOD;
	logic [7:0]  c_stable = RST_STABLE;
	logic [8:0]  c_mask = RST_DIR_MASK[8:0];
	logic [3:0]  c_sw = RST_SWITCH;

	logic        cand[NB];
	int unsigned cnt[NB];
	logic        stab[NB];
	logic [47:0] settle[NB];
	logic [47:0] rdue[NB];
	logic [47:0] poll_due = '0;
	bit          polled = 0;
	entry_t      edges[$];
	logic [31:0] drops = '0;
	logic [31:0] ovf = '0;
	bit          sw_lat = 0, sw_lvl = 0, sw_mov = 0;

	request_t pending[$];
	outcome_t expected[$];
	request_t cur_req;
	int       errors = 0;
	int       send_idle = 38, recv_idle = 54;
	int       hold_ticket = 0, hold_served = 0, hold_left = 0;
	int       cycles = 0;
	logic [47:0] now_t = '0;
	logic [8:0]  raw_t = '0;

	initial begin
		for (int i = 0; i < NB; i++) begin
			cand[i] = 0; cnt[i] = 0; stab[i] = 0; settle[i] = '0; rdue[i] = '0;
		end
	end

	function automatic logic [47:0] sat48(input logic [47:0] a, input logic [23:0] b);
		logic [48:0] s;
		s = {1'b0, a} + {25'b0, b};
		return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
	endfunction

	function automatic bit queue_edge(input logic [47:0] t, input logic [3:0] b, input kind_t k);
		int i;
		entry_t e;
		if (k == KIND_REPEAT) begin
			foreach (edges[j])
				if (edges[j].kind == KIND_REPEAT && edges[j].button == b) begin
					drops++;
					return 1;
				end
		end else begin
			i = 0;
			while (i < edges.size())
				if (edges[i].kind == KIND_REPEAT && edges[i].button == b)
					edges.delete(i);
				else
					i++;
		end
		if (edges.size() >= QD) begin
			if (k == KIND_REPEAT) begin
				drops++;
				return 1;
			end
			for (i = 0; i < edges.size(); i++)
				if (edges[i].kind == KIND_REPEAT) begin
					edges.delete(i);
					drops++;
					break;
				end
		end
		if (edges.size() >= QD) begin
			ovf++;
			return 0;
		end
		e.tstamp = t;
		e.button = b;
		e.kind = k;
		edges.push_back(e);
		return 1;
	endfunction

	task automatic sample_buttons(input logic [47:0] now, input logic [8:0] raw,
		output logic status);
		int unsigned thr;
		bit cont;
		logic r;
		status = 0;
		thr = (c_stable < 2) ? 2 : c_stable;
		if (polled && now < poll_due)
			return;
		cont = !polled || ({16'b0, now} < {16'b0, poll_due} + {44'b0, c_poll});
		polled = 1;
		poll_due = sat48(now, {4'b0, c_poll});
		if (!cont)
			for (int i = 0; i < NB; i++) cnt[i] = 0;
		for (int i = 0; i < NB; i++) begin
			r = raw[i];
			if (r != cand[i] || cnt[i] == 0) begin
				cand[i] = r;
				cnt[i] = 1;
			end else if (cnt[i] < thr) begin
				cnt[i]++;
				if (cnt[i] == thr) settle[i] = now;
			end
			if (cnt[i] < thr) continue;
			if (i == c_sw) begin
				if (!sw_lat) begin
					sw_lvl = r;
					sw_lat = 1;
				end else if (r != sw_lvl) begin
					sw_mov = 1;
				end
				continue;
			end
			if (r != stab[i]) begin
				if (!queue_edge(settle[i], 4'(i), r ? KIND_PRESS : KIND_RELEASE)) begin
					status = 1;
					continue;
				end
				stab[i] = r;
				rdue[i] = sat48(now, c_delay);
			end else if (r && c_mask[i] && now >= rdue[i]) begin
				void'(queue_edge(now, 4'(i), KIND_REPEAT));
				rdue[i] = sat48(now, c_period);
			end
		end
	endtask

	task automatic predict(input request_t rq);
		outcome_t o;
		logic st;
		o = '0;
		if (rq.op == CMD_POLL) begin
			sample_buttons(rq.now, rq.raw, st);
			o.status = st;
		end else if (edges.size() > 0) begin
			o.valid = 1;
			o.etime = edges[0].tstamp;
			o.btn = edges[0].button;
			o.kind = edges[0].kind;
			void'(edges.pop_front());
		end
		o.sw_ready = sw_lat;
		o.sw_level = sw_lvl;
		o.sw_changed = sw_mov;
		o.drops = drops;
		o.ovf = ovf;
		expected.push_back(o);
	endtask

	always @(posedge clk) begin
		if (cfg_valid && cfg_ready)
			case (cfg_index)
				CFG_POLL_PERIOD:   c_poll = cfg_data[19:0];
				CFG_REPEAT_DELAY:  c_delay = cfg_data;
				CFG_REPEAT_PERIOD: c_period = cfg_data;
				CFG_STABLE:        c_stable = cfg_data[7:0];
				CFG_DIR_MASK:      c_mask = cfg_data[8:0];
				CFG_SWITCH:        c_sw = cfg_data[3:0];
				default: ;
			endcase
	end

	// Request driver.
	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			predict(cur_req);
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (pending.size() > 0 && $urandom_range(99) >= send_idle) begin
				cur_req = pending.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {7'b0, cur_req.raw, cur_req.now};
				s_tuser <= cur_req.op;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Long receiver hold-off, so the block backs up into its input.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_ticket) begin
			hold_served <= hold_ticket;
			hold_left <= HOLD_CYCLES;
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		outcome_t got, want;
		if (m_tvalid && m_tready) begin
			got.status = m_tdata[0];
			got.valid = m_tuser;
			got.etime = m_tdata[48:1];
			got.btn = m_tdata[52:49];
			got.kind = m_tdata[54:53];
			got.sw_ready = m_tdata[55];
			got.sw_level = m_tdata[56];
			got.sw_changed = m_tdata[57];
			got.drops = m_tdata[89:58];
			got.ovf = m_tdata[121:90];
			if (expected.size() == 0) begin
				if (errors < 10)
					$display("unexpected result %h", got);
				errors++;
			end else begin
				want = expected.pop_front();
				if (got.status !== want.status || got.valid !== want.valid ||
					got.etime !== want.etime || got.btn !== want.btn ||
					got.kind !== want.kind || got.sw_ready !== want.sw_ready ||
					got.sw_level !== want.sw_level || got.sw_changed !== want.sw_changed ||
					got.drops !== want.drops || got.ovf !== want.ovf) begin
					if (errors < 10) begin
						$display("mismatch: status %b/%b valid %b/%b time %h/%h btn %0d/%0d",
							want.status, got.status, want.valid, got.valid,
							want.etime, got.etime, want.btn, got.btn);
						$display("  kind %0d/%0d sw %b%b%b/%b%b%b drops %0d/%0d ovf %0d/%0d",
							want.kind, got.kind, want.sw_ready, want.sw_level,
							want.sw_changed, got.sw_ready, got.sw_level, got.sw_changed,
							want.drops, got.drops, want.ovf, got.ovf);
					end
					errors++;
				end
			end
		end
		m_tready <= arst_n && hold_left == 0 && $urandom_range(99) >= recv_idle;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("button_debounce_repeat_queue_test: errors");
			$finish;
		end
	end

	task automatic add_poll(input logic [47:0] t, input logic [8:0] raw);
		request_t rq;
		rq.op = CMD_POLL;
		rq.now = t;
		rq.raw = raw;
		pending.push_back(rq);
	endtask

	task automatic add_pop();
		request_t rq;
		rq.op = CMD_POP;
		rq.now = 48'({$urandom, $urandom});
		rq.raw = 9'($urandom);
		pending.push_back(rq);
	endtask

	task automatic drain();
		while (pending.size() > 0 || expected.size() > 0 || s_tvalid)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_regs(input int p, input int d, input int per, input int st,
		input int msk, input int sw);
		logic [CFG_IDX_W-1:0] idx[6];
		int val[6];
		int k;
		idx = '{CFG_POLL_PERIOD, CFG_REPEAT_DELAY, CFG_REPEAT_PERIOD, CFG_STABLE,
			CFG_DIR_MASK, CFG_SWITCH};
		val = '{p, d, per, st, msk, sw};
		k = 0;
		cfg_index <= idx[0];
		cfg_data <= 24'(val[0]);
		cfg_valid <= 1'b1;
		while (k < 6) begin
			@(posedge clk);
			if (cfg_ready) begin
				k++;
				if (k < 6) begin
					cfg_index <= idx[k];
					cfg_data <= 24'(val[k]);
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
		// Let the register shadow settle before the traffic reads it.
		@(posedge clk);
	endtask

	// Held patterns with mostly on-time polls, some early ones, some gaps, and pops between.
	task automatic add_traffic(input int n_items, input int pop_pct, input int hold_max);
		int made, hold;
		logic [47:0] step, per;
		made = 0;
		per = {28'b0, c_poll};
		while (made < n_items) begin
			if ($urandom_range(3) == 0)
				raw_t = 9'($urandom);
			else
				raw_t[$urandom_range(8)] = ~raw_t[$urandom_range(8)];
			hold = $urandom_range(hold_max, 1);
			for (int j = 0; j < hold && made < n_items; j++) begin
				if ($urandom_range(99) < pop_pct) begin
					add_pop();
					made++;
				end
				case ($urandom_range(19))
					0: step = '0;
					1: step = per >> 1;
					2: step = 2 * per + 1 + $urandom_range(50);
					default: step = per + $urandom_range(2);
				endcase
				now_t = now_t + step;
				add_poll(now_t, raw_t);
				made++;
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset settings.
		add_pop();
		add_poll(48'd0, 9'h1FF);
		add_poll(48'd10000, 9'h1FF);
		add_poll(48'd20000, 9'h1FF);
		add_poll(48'd25000, 9'h000);
		repeat (3) add_pop();
		add_poll(48'd40000, 9'h000);
		add_poll(48'd50000, 9'h000);
		add_poll(48'd60000, 9'h000);
		add_poll(48'd200000, 9'h1FF);
		add_poll(48'd210000, 9'h1FF);
		repeat (6) add_pop();
		now_t = 48'd210000;
		drain();

		write_regs(10, 30, 20, 3, 'h1FF, 8);
		add_traffic(250, 15, 10);
		while (pending.size() > 150) @(posedge clk);
		hold_ticket++;
		drain();

		send_idle = 54;
		recv_idle = 38;
		write_regs(1, 0, 1, 0, 'h0AA, 15);
		now_t = 48'({$urandom, $urandom}) >> 1;
		add_traffic(250, 45, 6);
		drain();

		// Zero poll period: nothing may ever settle.
		write_regs(0, 5, 5, 1, 'h1FF, 0);
		add_traffic(60, 30, 4);
		drain();

		send_idle = 0;
		recv_idle = 0;
		write_regs(1000000, 10000000, 1, 255, 'h1FF, 3);
		add_traffic(320, 20, 300);
		drain();

		write_regs(7, 50, 25, 2, 'h000, 7);
		add_traffic(250, 35, 8);
		drain();

		// Times at the top of the range drive the due times into saturation.
		write_regs(10000, 400000, 100000, 3, 'h1FF, 7);
		add_poll(48'hFFFF_FFFF_FFFA, 9'h1FF);
		add_poll(48'hFFFF_FFFF_FFFB, 9'h1FF);
		repeat (6) add_poll(48'hFFFF_FFFF_FFFF, 9'h1FF);
		repeat (5) add_pop();
		drain();

		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("button_debounce_repeat_queue_test: clean");
		else
			$display("button_debounce_repeat_queue_test: errors");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/bdrq_pkg.sv
sv/bdrq_ctrl.sv
sv/bdrq_dp.sv
sv/button_debounce_repeat_queue.sv
sv/bdrq_chk.sv
bench/button_debounce_repeat_queue_test.sv
